@@ src/s2ms_pkg.sv @@
`default_nettype none
package s2ms_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
endpackage
`default_nettype wire

@@ src/s2ms_isqrt_pipe.sv @@
`default_nettype none
// Integer square root, floor, one result bit per stage.
module s2ms_isqrt_pipe #(
    parameter int IN_W = 64,
    parameter int SB_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [IN_W-1:0]     i_rad,
    input  logic [SB_W-1:0]     i_sb,
    output logic                o_valid,
    output logic [IN_W/2-1:0]   o_root,
    output logic [SB_W-1:0]     o_sb
);
    localparam int OW  = IN_W / 2;
    localparam int RMW = OW + 1;

    logic [IN_W-1:0] r_x    [OW];
    logic [OW-1:0]   r_root [OW];
    logic [RMW-1:0]  r_rem  [OW];
    logic [SB_W-1:0] r_sb   [OW];
    logic            r_vld  [OW];

    genvar g;
    for (g = 0; g < OW; g++) begin : g_stage
        logic [IN_W-1:0] x_in;
        logic [OW-1:0]   root_in;
        logic [RMW-1:0]  rem_in;
        logic [SB_W-1:0] sb_in;
        logic            vld_in;
        logic [RMW+1:0]  cur;
        logic [RMW+1:0]  trial;
        logic [RMW+1:0]  diff;
        logic            take;

        if (g == 0) begin : g_first
            assign x_in    = i_rad;
            assign root_in = '0;
            assign rem_in  = '0;
            assign sb_in   = i_sb;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign x_in    = r_x[g-1];
            assign root_in = r_root[g-1];
            assign rem_in  = r_rem[g-1];
            assign sb_in   = r_sb[g-1];
            assign vld_in  = r_vld[g-1];
        end

        assign cur   = {rem_in, x_in[IN_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign diff  = cur - trial;
        assign take  = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]    <= {x_in[IN_W-3:0], 2'b00};
                r_root[g] <= {root_in[OW-2:0], take};
                r_rem[g]  <= take ? diff[RMW-1:0] : cur[RMW-1:0];
                r_sb[g]   <= sb_in;
            end
        end
    end

    assign o_valid = r_vld[OW-1];
    assign o_root  = r_root[OW-1];
    assign o_sb    = r_sb[OW-1];
endmodule
`default_nettype wire

@@ src/s2ms_div_pipe.sv @@
`default_nettype none
// Unsigned restoring divider, one quotient bit per stage.
module s2ms_div_pipe #(
    parameter int N_W  = 48,
    parameter int D_W  = 25,
    parameter int SB_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [N_W-1:0]   i_num,
    input  logic [D_W-1:0]   i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [N_W-1:0]   o_quo,
    output logic [SB_W-1:0]  o_sb
);
    // dividend shifts out the top while quotient bits shift in below
    logic [N_W-1:0]  r_x   [N_W];
    logic [D_W-1:0]  r_rem [N_W];
    logic [D_W-1:0]  r_den [N_W];
    logic [SB_W-1:0] r_sb  [N_W];
    logic            r_vld [N_W];

    genvar g;
    for (g = 0; g < N_W; g++) begin : g_stage
        logic [N_W-1:0]  x_in;
        logic [D_W-1:0]  rem_in;
        logic [D_W-1:0]  den_in;
        logic [SB_W-1:0] sb_in;
        logic            vld_in;
        logic [D_W:0]    cur;
        logic [D_W:0]    diff;
        logic            take;

        if (g == 0) begin : g_first
            assign x_in   = i_num;
            assign rem_in = '0;
            assign den_in = i_den;
            assign sb_in  = i_sb;
            assign vld_in = i_valid;
        end else begin : g_next
            assign x_in   = r_x[g-1];
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign sb_in  = r_sb[g-1];
            assign vld_in = r_vld[g-1];
        end

        assign cur  = {rem_in, x_in[N_W-1]};
        assign take = (cur >= {1'b0, den_in});
        assign diff = cur - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]   <= {x_in[N_W-2:0], take};
                r_rem[g] <= take ? diff[D_W-1:0] : cur[D_W-1:0];
                r_den[g] <= den_in;
                r_sb[g]  <= sb_in;
            end
        end
    end

    assign o_valid = r_vld[N_W-1];
    assign o_quo   = r_x[N_W-1];
    assign o_sb    = r_sb[N_W-1];
endmodule
`default_nettype wire

@@ src/sym2x2_matrix_sqrt_top.sv @@
// Principal square root of a symmetric 2x2 matrix [a11 a12; a12 a22] in signed
// fixed point (DATA_WIDTH bits, FRAC_BITS fraction bits; Q16.16 by default). One
// item is taken every clock while the skid stage is empty (s_axis_tready high).
// Each item passes through the two bit-serial square root pipelines and the
// three parallel divider pipelines. A negative determinant or a non-positive
// trace term sets tuser (invalid) and zeroes the data; quotients saturate.
`default_nettype none
module sym2x2_matrix_sqrt_top #(
    parameter int DATA_WIDTH = s2ms_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = s2ms_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // a11, a12, a22 from bit 0 up
    input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // b11, b12, b22 from bit 0 up
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // invalid
    output logic                                  m_axis_tuser
);
    import s2ms_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int TD_W  = ((3*W+7)/8)*8;
    localparam int TW    = (W + F + 2) / 2;
    localparam int QW    = W + F;
    localparam int SB1_W = 3*W + 1;
    localparam int SB2_W = 4*W + 1;

    logic r_skid_vld;
    logic en;
    assign en = !r_skid_vld;
    assign s_axis_tready = en;

    // stage A: capture and magnitudes
    logic [W-1:0] in11, in12, in22;
    assign in11 = s_axis_tdata[W-1:0];
    assign in12 = s_axis_tdata[2*W-1:W];
    assign in22 = s_axis_tdata[3*W-1:2*W];

    logic         r_a_vld;
    logic [W-1:0] r_a11, r_a12, r_a22, r_m11, r_m12, r_m22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a11 <= in11;
            r_a12 <= in12;
            r_a22 <= in22;
            r_m11 <= in11[W-1] ? -in11 : in11;
            r_m12 <= in12[W-1] ? -in12 : in12;
            r_m22 <= in22[W-1] ? -in22 : in22;
        end
    end

    // stage B: products
    logic           r_b_vld;
    logic [W-1:0]   r_b11, r_b12, r_b22;
    logic [2*W-1:0] r_prod, r_sq;
    logic           r_prod_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b11      <= r_a11;
            r_b12      <= r_a12;
            r_b22      <= r_a22;
            r_prod     <= (2*W)'(r_m11) * (2*W)'(r_m22);
            r_sq       <= (2*W)'(r_m12) * (2*W)'(r_m12);
            r_prod_neg <= r_a11[W-1] ^ r_a22[W-1];
        end
    end

    // stage C: determinant
    logic           r_c_vld;
    logic [W-1:0]   r_c11, r_c12, r_c22;
    logic [2*W-1:0] r_det;
    logic           r_c_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c11   <= r_b11;
            r_c12   <= r_b12;
            r_c22   <= r_b22;
            r_det   <= r_prod - r_sq;
            r_c_inv <= (r_prod_neg && (r_prod != '0)) || (r_prod < r_sq);
        end
    end

    // s = floor(sqrt(det))
    logic             s1_vld;
    logic [W-1:0]     s1_root;
    logic [SB1_W-1:0] s1_sb;

    s2ms_isqrt_pipe #(.IN_W(2*W), .SB_W(SB1_W)) u_sqrt_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_vld),
        .i_rad   (r_det),
        .i_sb    ({r_c_inv, r_c22, r_c12, r_c11}),
        .o_valid (s1_vld),
        .o_root  (s1_root),
        .o_sb    (s1_sb)
    );

    // stage D: radicand a11 + a22 + 2s
    logic [W+2:0] rad;
    assign rad = (W+3)'($signed(s1_sb[W-1:0])) + (W+3)'($signed(s1_sb[3*W-1:2*W]))
               + (W+3)'({s1_root, 1'b0});

    logic             r_d_vld;
    logic [2*TW-1:0]  r_d_rad;
    logic [SB2_W-1:0] r_d_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_rad <= (2*TW)'({rad[W:0], {F{1'b0}}});
            r_d_sb  <= {s1_sb[3*W] | rad[W+2] | (rad == '0), s1_root, s1_sb[3*W-1:0]};
        end
    end

    // t = floor(sqrt(rad << F))
    logic             s2_vld;
    logic [TW-1:0]    s2_root;
    logic [SB2_W-1:0] s2_sb;

    s2ms_isqrt_pipe #(.IN_W(2*TW), .SB_W(SB2_W)) u_sqrt_rad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_vld),
        .i_rad   (r_d_rad),
        .i_sb    (r_d_sb),
        .o_valid (s2_vld),
        .o_root  (s2_root),
        .o_sb    (s2_sb)
    );

    // stage E: numerators
    logic          r_e_vld;
    logic [W:0]    r_n11, r_n22;
    logic [W-1:0]  r_n12;
    logic [TW-1:0] r_e_t;
    logic          r_e_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n11   <= (W+1)'($signed(s2_sb[W-1:0])) + {1'b0, s2_sb[4*W-1:3*W]};
            r_n22   <= (W+1)'($signed(s2_sb[3*W-1:2*W])) + {1'b0, s2_sb[4*W-1:3*W]};
            r_n12   <= s2_sb[2*W-1:W];
            r_e_t   <= s2_root;
            r_e_inv <= s2_sb[4*W] | (s2_root == '0);
        end
    end

    // stage F: sign and magnitude
    logic          r_f_vld;
    logic [W-1:0]  r_f_m11, r_f_m12, r_f_m22;
    logic          r_f_ng11, r_f_ng12, r_f_ng22;
    logic [TW-1:0] r_f_t;
    logic          r_f_inv;
    logic [W:0]    neg11, neg22;

    assign neg11 = -r_n11;
    assign neg22 = -r_n22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_m11  <= r_n11[W] ? neg11[W-1:0] : r_n11[W-1:0];
            r_f_m22  <= r_n22[W] ? neg22[W-1:0] : r_n22[W-1:0];
            r_f_m12  <= r_n12[W-1] ? -r_n12 : r_n12;
            r_f_ng11 <= r_n11[W];
            r_f_ng22 <= r_n22[W];
            r_f_ng12 <= r_n12[W-1];
            r_f_t    <= r_e_t;
            r_f_inv  <= r_e_inv;
        end
    end

    // three quotient lanes
    logic          q_vld;
    logic [QW-1:0] q11, q12, q22;
    logic [1:0]    q11_sb;
    logic          q12_sb, q22_sb;

    s2ms_div_pipe #(.N_W(QW), .D_W(TW), .SB_W(2)) u_div11 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_vld),
        .i_num   ({r_f_m11, {F{1'b0}}}),
        .i_den   (r_f_t),
        .i_sb    ({r_f_inv, r_f_ng11}),
        .o_valid (q_vld),
        .o_quo   (q11),
        .o_sb    (q11_sb)
    );

    s2ms_div_pipe #(.N_W(QW), .D_W(TW), .SB_W(1)) u_div12 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_vld),
        .i_num   ({r_f_m12, {F{1'b0}}}),
        .i_den   (r_f_t),
        .i_sb    (r_f_ng12),
        .o_valid (),
        .o_quo   (q12),
        .o_sb    (q12_sb)
    );

    s2ms_div_pipe #(.N_W(QW), .D_W(TW), .SB_W(1)) u_div22 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_vld),
        .i_num   ({r_f_m22, {F{1'b0}}}),
        .i_den   (r_f_t),
        .i_sb    (r_f_ng22),
        .o_valid (),
        .o_quo   (q22),
        .o_sb    (q22_sb)
    );

    // saturate, restore sign, zero when invalid
    function automatic logic [W-1:0] sat_sign(input logic [QW-1:0] q, input logic ng);
        logic [QW-1:0] lim;
        logic [QW-1:0] mag;
        lim = (QW'(1) << (W-1)) - QW'(1) + QW'(ng);
        mag = (q > lim) ? lim : q;
        return ng ? W'(-mag) : W'(mag);
    endfunction

    logic         res_inv;
    logic [W-1:0] res11, res12, res22;

    assign res_inv = q11_sb[1];
    assign res11   = res_inv ? '0 : sat_sign(q11, q11_sb[0]);
    assign res12   = res_inv ? '0 : sat_sign(q12, q12_sb);
    assign res22   = res_inv ? '0 : sat_sign(q22, q22_sb);

    // output register plus skid stage
    logic           r_out_vld;
    logic [3*W-1:0] r_out_data;
    logic           r_out_inv;
    logic [3*W-1:0] r_skid_data;
    logic           r_skid_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (!r_out_vld || m_axis_tready) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_out_data <= r_skid_data;
                    r_out_inv  <= r_skid_inv;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld  <= q_vld && en;
                    r_out_data <= {res22, res12, res11};
                    r_out_inv  <= res_inv;
                end
            end else if (q_vld && en) begin
                r_skid_vld  <= 1'b1;
                r_skid_data <= {res22, res12, res11};
                r_skid_inv  <= res_inv;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = TD_W'(r_out_data);
    assign m_axis_tuser  = r_out_inv;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds an item while output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !m_axis_tready))
        else $error("skid filled without an output stall");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_out_data == '0))
        else $error("invalid result carries nonzero data");
endmodule
`default_nettype wire
